### src/ibh_pkg.sv
// -----------------------------------------------------------------------------
// ibh_pkg
// Shared types and constants for the indexed binary heap.
// -----------------------------------------------------------------------------
package ibh_pkg;

	localparam int ID_W           = 7;
	localparam int NUM_IDS        = 128;
	localparam int VALUE_W        = 32;
	localparam int COUNT_W        = 8;
	localparam int DEF_CAPACITY   = 128;
	localparam int DEF_VALUE_BITS = 32;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_POP_EMPTY = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_RSVD      = 2'd3
	} stat_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MAP_CHK,
		S_IMP_CMP,
		S_UP_ISSUE,
		S_UP_CMP,
		S_POP_LD,
		S_DN_ISSUE,
		S_DN_RD2,
		S_DN_SEL,
		S_DN_CMP,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic [ID_W-1:0]    entry_index;
		logic [VALUE_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [ID_W-1:0]    top_index;
		logic [VALUE_W-1:0] top_value;
		logic [COUNT_W-1:0] count;
		logic               is_empty;
		logic [1:0]         status;
	} rsp_t;

endpackage

### src/ibh_ram.sv
// -----------------------------------------------------------------------------
// ibh_ram
// Generic single-write, single-read RAM with a registered read port.
// -----------------------------------------------------------------------------
module ibh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### src/indexed_binary_heap_top.sv
// -----------------------------------------------------------------------------
// indexed_binary_heap_top
// Indexed binary priority queue with a position map and improve-key push (min or max order).
// -----------------------------------------------------------------------------
// channel   signals                 handshake
// command   cmd                     taken on start && !busy
// result    rsp                     one cycle on done, no back-pressure
// config    cfg_we, cfg_wdata       written when cfg_we is high
//
// Clear, an unused code and a pop on empty go from idle straight to the result state;
// an insert when full ends after the map check, a pop of the last entry after the load.
// Push: map check, an improve compare for a present entry (done when the value is
// not better), then per level climbed a parent read and a compare. Pop: a load, then
// per level descended child reads, a right-child select if any, and a compare.
// Reset empties the heap at once through per-entry valid bits on the map.
// Results cannot be stalled; busy stays high until the result cycle ends.
// -----------------------------------------------------------------------------
module indexed_binary_heap_top #(
	parameter int CAPACITY   = ibh_pkg::DEF_CAPACITY,
	parameter int VALUE_BITS = ibh_pkg::DEF_VALUE_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ibh_pkg::cmd_t cmd,
	output logic          done,
	output ibh_pkg::rsp_t rsp,
	input  logic          cfg_we,
	input  logic          cfg_wdata
);

	localparam int LIM    = (CAPACITY < ibh_pkg::NUM_IDS) ? CAPACITY : ibh_pkg::NUM_IDS;
	localparam int SLOT_W = $clog2(LIM + 1);
	localparam int ID_W   = ibh_pkg::ID_W;
	localparam int ENT_W  = ID_W + VALUE_BITS;

	ibh_pkg::state_t state_q, state_d;

	logic [ID_W-1:0]       id_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [SLOT_W-1:0]     pos_q;
	logic [SLOT_W-1:0]     count_q;
	logic [SLOT_W-1:0]     bc_q;
	logic [ENT_W-1:0]      item_q;
	logic [ENT_W-1:0]      best_q;
	logic [ENT_W-1:0]      root_q;
	logic [1:0]            status_q;
	logic                  order_q;
	logic [ibh_pkg::NUM_IDS-1:0] valid_q;

	// memory ports
	logic                    heap_we, heap_re;
	logic [SLOT_W-1:0]       heap_waddr, heap_raddr;
	logic [ENT_W-1:0]        heap_wdata, heap_rdata;
	logic                    map_we, map_re;
	logic [ID_W-1:0]         map_waddr, map_raddr;
	logic [SLOT_W-1:0]       map_wdata, map_rdata;

	logic [ibh_pkg::VALUE_W+VALUE_BITS-1:0] val_ext;
	logic [VALUE_BITS-1:0]   cmd_val;
	logic [SLOT_W:0]         child;
	logic [SLOT_W:0]         count_ext;
	logic [SLOT_W-1:0]       parent;
	logic                    present;
	logic                    accept;

	function automatic logic better(input logic mx, input logic [VALUE_BITS-1:0] a,
			input logic [VALUE_BITS-1:0] b);
		better = mx ? (a > b) : (a < b);
	endfunction

	function automatic logic [VALUE_BITS-1:0] vpart(input logic [ENT_W-1:0] e);
		vpart = e[VALUE_BITS-1:0];
	endfunction

	function automatic logic [ID_W-1:0] ipart(input logic [ENT_W-1:0] e);
		ipart = e[ENT_W-1:VALUE_BITS];
	endfunction

	assign accept    = start && (state_q == ibh_pkg::S_IDLE);
	assign val_ext   = {{VALUE_BITS{1'b0}}, cmd.value};
	assign cmd_val   = val_ext[VALUE_BITS-1:0];
	assign child     = {pos_q, 1'b0};
	assign count_ext = {1'b0, count_q};
	assign parent    = pos_q >> 1;
	assign present   = valid_q[id_q] && (map_rdata != '0) && (map_rdata <= count_q);

	ibh_ram #(.WIDTH(ENT_W), .DEPTH(LIM + 1)) u_heap_ram (
		.clk   (clk),
		.we    (heap_we),
		.waddr (heap_waddr),
		.wdata (heap_wdata),
		.re    (heap_re),
		.raddr (heap_raddr),
		.rdata (heap_rdata)
	);

	ibh_ram #(.WIDTH(SLOT_W), .DEPTH(ibh_pkg::NUM_IDS)) u_map_ram (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.re    (map_re),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ibh_pkg::S_IDLE: begin
				if (start) begin
					case (cmd.operation)
						ibh_pkg::OP_PUSH: state_d = ibh_pkg::S_MAP_CHK;
						ibh_pkg::OP_POP:
							state_d = (count_q == '0) ? ibh_pkg::S_DONE : ibh_pkg::S_POP_LD;
						default: state_d = ibh_pkg::S_DONE;
					endcase
				end
			end
			ibh_pkg::S_MAP_CHK: begin
				if (present) begin
					state_d = ibh_pkg::S_IMP_CMP;
				end else if (count_q >= SLOT_W'(LIM)) begin
					state_d = ibh_pkg::S_DONE;
				end else begin
					state_d = ibh_pkg::S_UP_ISSUE;
				end
			end
			ibh_pkg::S_IMP_CMP: begin
				state_d = better(order_q, val_q, vpart(heap_rdata)) ?
					ibh_pkg::S_UP_ISSUE : ibh_pkg::S_DONE;
			end
			ibh_pkg::S_UP_ISSUE: begin
				state_d = (pos_q == SLOT_W'(1)) ? ibh_pkg::S_DONE : ibh_pkg::S_UP_CMP;
			end
			ibh_pkg::S_UP_CMP: begin
				state_d = better(order_q, vpart(item_q), vpart(heap_rdata)) ?
					ibh_pkg::S_UP_ISSUE : ibh_pkg::S_DONE;
			end
			ibh_pkg::S_POP_LD: begin
				state_d = (count_q == SLOT_W'(1)) ? ibh_pkg::S_DONE : ibh_pkg::S_DN_ISSUE;
			end
			ibh_pkg::S_DN_ISSUE: begin
				state_d = (child > count_ext) ? ibh_pkg::S_DONE : ibh_pkg::S_DN_RD2;
			end
			ibh_pkg::S_DN_RD2: begin
				state_d = (child < count_ext) ? ibh_pkg::S_DN_SEL : ibh_pkg::S_DN_CMP;
			end
			ibh_pkg::S_DN_SEL: state_d = ibh_pkg::S_DN_CMP;
			ibh_pkg::S_DN_CMP: begin
				state_d = better(order_q, vpart(best_q), vpart(item_q)) ?
					ibh_pkg::S_DN_ISSUE : ibh_pkg::S_DONE;
			end
			ibh_pkg::S_DONE: state_d = ibh_pkg::S_IDLE;
			default: state_d = ibh_pkg::S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		heap_we    = 1'b0;
		heap_waddr = pos_q;
		heap_wdata = item_q;
		heap_re    = 1'b0;
		heap_raddr = pos_q;
		map_we     = 1'b0;
		map_waddr  = ipart(item_q);
		map_wdata  = pos_q;
		map_re     = 1'b0;
		map_raddr  = cmd.entry_index;
		case (state_q)
			ibh_pkg::S_IDLE: begin
				map_re     = accept && (cmd.operation == ibh_pkg::OP_PUSH);
				heap_re    = accept && (cmd.operation == ibh_pkg::OP_POP);
				heap_raddr = count_q;
			end
			ibh_pkg::S_MAP_CHK: begin
				heap_re    = present;
				heap_raddr = map_rdata;
			end
			ibh_pkg::S_UP_ISSUE: begin
				// root reached: drop the item here
				if (pos_q == SLOT_W'(1)) begin
					heap_we = 1'b1;
					map_we  = 1'b1;
				end else begin
					heap_re    = 1'b1;
					heap_raddr = parent;
				end
			end
			ibh_pkg::S_UP_CMP: begin
				if (better(order_q, vpart(item_q), vpart(heap_rdata))) begin
					heap_wdata = heap_rdata;
					map_waddr  = ipart(heap_rdata);
				end
				heap_we = 1'b1;
				map_we  = 1'b1;
			end
			ibh_pkg::S_DN_ISSUE: begin
				if (child > count_ext) begin
					heap_we = 1'b1;
					map_we  = 1'b1;
				end else begin
					heap_re    = 1'b1;
					heap_raddr = child[SLOT_W-1:0];
				end
			end
			ibh_pkg::S_DN_RD2: begin
				heap_re    = child < count_ext;
				heap_raddr = child[SLOT_W-1:0] + SLOT_W'(1);
			end
			ibh_pkg::S_DN_CMP: begin
				if (better(order_q, vpart(best_q), vpart(item_q))) begin
					heap_wdata = best_q;
					map_waddr  = ipart(best_q);
				end
				heap_we = 1'b1;
				map_we  = 1'b1;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ibh_pkg::S_IDLE;
			count_q <= '0;
			valid_q <= '0;
			order_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				order_q <= cfg_wdata;
			end
			if (map_we) begin
				valid_q[map_waddr] <= 1'b1;
			end
			case (state_q)
				ibh_pkg::S_IDLE: begin
					if (accept && cmd.operation == ibh_pkg::OP_CLEAR) begin
						valid_q <= '0;
						count_q <= '0;
					end
					if (accept && cmd.operation == ibh_pkg::OP_POP && count_q != '0) begin
						valid_q[ipart(root_q)] <= 1'b0;
					end
				end
				ibh_pkg::S_MAP_CHK: begin
					if (!present && count_q < SLOT_W'(LIM)) begin
						count_q <= count_q + SLOT_W'(1);
					end
				end
				ibh_pkg::S_POP_LD: count_q <= count_q - SLOT_W'(1);
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (heap_we && heap_waddr == SLOT_W'(1)) begin
			root_q <= heap_wdata;
		end
		case (state_q)
			ibh_pkg::S_IDLE: begin
				if (accept) begin
					id_q     <= cmd.entry_index;
					val_q    <= cmd_val;
					status_q <= (cmd.operation == ibh_pkg::OP_POP && count_q == '0) ?
						ibh_pkg::STAT_POP_EMPTY : ibh_pkg::STAT_OK;
				end
			end
			ibh_pkg::S_MAP_CHK: begin
				item_q <= {id_q, val_q};
				if (present) begin
					pos_q <= map_rdata;
				end else if (count_q >= SLOT_W'(LIM)) begin
					status_q <= ibh_pkg::STAT_FULL;
				end else begin
					pos_q <= count_q + SLOT_W'(1);
				end
			end
			ibh_pkg::S_UP_CMP: begin
				if (better(order_q, vpart(item_q), vpart(heap_rdata))) begin
					pos_q <= parent;
				end
			end
			ibh_pkg::S_POP_LD: begin
				item_q <= heap_rdata;
				pos_q  <= SLOT_W'(1);
			end
			ibh_pkg::S_DN_RD2: begin
				best_q <= heap_rdata;
				bc_q   <= child[SLOT_W-1:0];
			end
			ibh_pkg::S_DN_SEL: begin
				// take the right child only when strictly better
				if (better(order_q, vpart(heap_rdata), vpart(best_q))) begin
					best_q <= heap_rdata;
					bc_q   <= bc_q + SLOT_W'(1);
				end
			end
			ibh_pkg::S_DN_CMP: begin
				if (better(order_q, vpart(best_q), vpart(item_q))) begin
					pos_q <= bc_q;
				end
			end
			default: ;
		endcase
	end

	// result word
	always_comb begin
		busy               = (state_q != ibh_pkg::S_IDLE);
		done               = (state_q == ibh_pkg::S_DONE);
		rsp.count          = ibh_pkg::COUNT_W'(count_q);
		rsp.is_empty       = (count_q == '0);
		rsp.status         = status_q;
		rsp.top_index      = (count_q == '0) ? '0 : ipart(root_q);
		rsp.top_value      = (count_q == '0) ? '0 : ibh_pkg::VALUE_W'(vpart(root_q));
	end

endmodule

### src/ibh_checker.sv
// -----------------------------------------------------------------------------
// ibh_checker
// Port-level checks on the indexed binary heap, bound to the top level.
// -----------------------------------------------------------------------------
module ibh_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input ibh_pkg::rsp_t rsp
);

	// one result per command, then a free cycle
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result strobe held for two cycles");

	// an accepted command keeps the block busy
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("command accepted but block not busy");

	// result only while busy
	assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("result outside a command");

	// empty flag agrees with count
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.is_empty == (rsp.count == '0)))
		else $error("empty flag disagrees with count");

	// empty heap shows a zero top
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.is_empty) |-> (rsp.top_index == '0 && rsp.top_value == '0))
		else $error("empty heap shows a nonzero top");

endmodule

bind indexed_binary_heap_top ibh_checker u_ibh_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
